>>> design/cgsm_pkg.sv
// ----------------------------------------------------------------------------
// cgsm_pkg
// Shared types, constants and the microcode table of the code group set
// matcher: table geometry, request commands, control word layout and program.
// ----------------------------------------------------------------------------
package cgsm_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CODE_W      = 16;
	localparam int CMD_W       = 2;
	localparam int STEP_W      = 2;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	typedef logic [STEP_W-1:0] step_t;

	// Program addresses
	localparam step_t STEP_IDLE    = 2'd0;
	localparam step_t STEP_CHECK   = 2'd1;
	localparam step_t STEP_COMPARE = 2'd2;
	localparam step_t STEP_FINISH  = 2'd3;

	// Datapath operations
	typedef enum logic [1:0] {
		OP_ACCEPT = 2'd0,  // take a request, run append/clear or load the search
		OP_READ   = 2'd1,  // latch mid and read the probed entry
		OP_NARROW = 2'd2,  // compare probe, record a hit or narrow the span
		OP_REPORT = 2'd3   // latch the hit flag as result; strobe done on the last code
	} op_t;

	// Jump conditions
	typedef enum logic [1:0] {
		COND_ALWAYS      = 2'd0,
		COND_QUERY_START = 2'd1,
		COND_SPAN_EMPTY  = 2'd2,
		COND_MATCH       = 2'd3
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t on_true;
		step_t on_false;
		logic  busy;
	} ucode_t;

	// Control from sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic busy;
	} ctrl_t;

	// Status from datapath to sequencer
	typedef struct packed {
		logic query_start;
		logic span_empty;
		logic match;
	} status_t;

	// Microcode read-only table
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			STEP_IDLE:    w = '{OP_ACCEPT, COND_QUERY_START, STEP_CHECK,  STEP_IDLE,    1'b0};
			STEP_CHECK:   w = '{OP_READ,   COND_SPAN_EMPTY,  STEP_FINISH, STEP_COMPARE, 1'b1};
			STEP_COMPARE: w = '{OP_NARROW, COND_MATCH,       STEP_FINISH, STEP_CHECK,   1'b1};
			STEP_FINISH:  w = '{OP_REPORT, COND_ALWAYS,      STEP_IDLE,   STEP_IDLE,    1'b1};
			default:      w = '{OP_ACCEPT, COND_ALWAYS,      STEP_IDLE,   STEP_IDLE,    1'b0};
		endcase
		return w;
	endfunction

endpackage

>>> design/code_group_set_match.sv
// Append, clear and unused commands complete in the accept step; busy stays low.
// A query holds busy while it probes the table and reports; a hit ends the probes early.
// There are at most 9 probes for 256 entries; a probe is a read and a compare.
// The next request is taken on the first cycle busy is low again; the result of
// a group's last code strobes on done in that same cycle, and the receiver cannot stall it.
// Reset (arst_n low) empties the table count, clears the group hit flag and idles.
// ----------------------------------------------------------------------------
// code_group_set_match
// Code table, to be appended in ascending signed order by the user (the block does not
// sort it), with binary-search membership test over query groups, controlled by a
// microcoded sequencer driving a plain datapath.
module code_group_set_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cgsm_pkg::CMD_W-1:0]          cmd,
	input  logic signed [cgsm_pkg::CODE_W-1:0]  code_value,
	input  logic                                last_code,
	output logic                                done,
	output logic                                any_found
);
	import cgsm_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	// Program sequencer
	cgsm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Table and search datapath
	cgsm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.start      (start),
		.cmd        (cmd),
		.code_value (code_value),
		.last_code  (last_code),
		.status     (status),
		.done       (done),
		.any_found  (any_found)
	);

	assign busy = ctrl.busy;

endmodule

>>> design/cgsm_sequencer.sv
// ----------------------------------------------------------------------------
// cgsm_sequencer
// Step counter over the microcode table; evaluates the jump condition of the
// current control word against datapath status and picks the next step.
// ----------------------------------------------------------------------------
module cgsm_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  cgsm_pkg::status_t status,
	output cgsm_pkg::ctrl_t   ctrl
);
	import cgsm_pkg::*;

	step_t  pc_q;
	step_t  pc_next;
	ucode_t word;
	logic   taken;

	// Fetch and decode the current control word
	always_comb begin
		word = ucode_rom(pc_q);
		unique case (word.cond)
			COND_ALWAYS:      taken = 1'b1;
			COND_QUERY_START: taken = status.query_start;
			COND_SPAN_EMPTY:  taken = status.span_empty;
			COND_MATCH:       taken = status.match;
			default:          taken = 1'b1;
		endcase
		pc_next   = taken ? word.on_true : word.on_false;
		ctrl.op   = word.op;
		ctrl.busy = word.busy;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> design/cgsm_datapath.sv
// ----------------------------------------------------------------------------
// cgsm_datapath
// Table memory, entry count, search bounds and group hit flag, driven one
// operation per cycle by the sequencer's control word.
// ----------------------------------------------------------------------------
module cgsm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cgsm_pkg::ctrl_t                     ctrl,
	input  logic                                start,
	input  logic [cgsm_pkg::CMD_W-1:0]          cmd,
	input  logic signed [cgsm_pkg::CODE_W-1:0]  code_value,
	input  logic                                last_code,
	output cgsm_pkg::status_t                   status,
	output logic                                done,
	output logic                                any_found
);
	import cgsm_pkg::*;

	logic signed [CODE_W-1:0] mem [TABLE_DEPTH];
	logic signed [CODE_W-1:0] rdata_q;
	logic signed [CODE_W-1:0] code_q;
	logic                     last_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [IDX_W-1:0]         mid_q;
	logic                     hit_q;
	logic                     done_q;
	logic                     found_q;
	logic [CNT_W:0]           span_sum;
	logic [IDX_W-1:0]         mid_next;
	logic                     full;
	logic                     take;

	// Midpoint of the half-open span and status for the sequencer
	always_comb begin
		span_sum           = {1'b0, lo_q} + {1'b0, hi_q};
		mid_next           = span_sum[IDX_W:1];
		full               = (count_q == CNT_W'(TABLE_DEPTH));
		take               = (ctrl.op == OP_ACCEPT) && start;
		status.query_start = take && (cmd == CMD_QUERY);
		status.span_empty  = (lo_q >= hi_q);
		status.match       = (rdata_q == code_q);
	end

	// Table memory: append write and probe read
	always_ff @(posedge clk) begin
		if (take && (cmd == CMD_APPEND) && !full) begin
			mem[count_q[IDX_W-1:0]] <= code_value;
		end
		if (ctrl.op == OP_READ) begin
			rdata_q <= mem[mid_next];
		end
	end

	// Search payload: code, group flag, bounds, result value
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_ACCEPT: begin
				if (status.query_start) begin
					code_q <= code_value;
					last_q <= last_code;
					lo_q   <= '0;
					hi_q   <= count_q;
				end
			end
			OP_READ: begin
				mid_q <= mid_next;
			end
			OP_NARROW: begin
				if (!status.match) begin
					if (rdata_q > code_q) begin
						hi_q <= {1'b0, mid_q};
					end else begin
						lo_q <= {1'b0, mid_q} + CNT_W'(1);
					end
				end
			end
			OP_REPORT: begin
				found_q <= hit_q;
			end
			default: begin
			end
		endcase
	end

	// Control state: entry count, group hit flag, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ctrl.op)
				OP_ACCEPT: begin
					if (take) begin
						unique case (cmd)
							CMD_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_CLEAR: count_q <= '0;
							default: begin
							end
						endcase
					end
				end
				OP_NARROW: begin
					if (status.match) begin
						hit_q <= 1'b1;
					end
				end
				OP_REPORT: begin
					if (last_q) begin
						done_q <= 1'b1;
						hit_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done      = done_q;
	assign any_found = found_q;

endmodule
